[rtl/pbs_pkg.sv]
// Shared constants and register codes for the power button sequencer.
package pbs_pkg;

  // Fixed field and state widths
  localparam int TIME_W      = 32;
  localparam int SUM_W       = 32;
  localparam int HOLD_W      = 16;
  localparam int DEBOUNCE_W  = 10;
  localparam int THRESH_W    = 13;
  localparam int SAMPLE_W    = 10;

  // Default width of the battery sample counter
  localparam int SAMPLE_COUNT_BITS_DEFAULT = 16;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ON_HOLD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFF_HOLD  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHDN_WAIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BATT_THR  = 3'd4;

  // Register reset values
  localparam logic [HOLD_W-1:0]     ON_HOLD_RST   = 16'd1000;
  localparam logic [HOLD_W-1:0]     OFF_HOLD_RST  = 16'd3000;
  localparam logic [HOLD_W-1:0]     SHDN_WAIT_RST = 16'd10000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 10'd50;
  localparam logic [THRESH_W-1:0]   BATT_THR_RST  = 13'd3200;

endpackage

[rtl/pbs_ifs.sv]
// Valid/ready channel interfaces for sampling passes and status results.
interface pbs_pins_if;
  import pbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                button_level;
  logic                host_shutdown_level;
  logic [SAMPLE_W-1:0] battery_sample;
  logic                tick;

  modport source (
    output valid, button_level, host_shutdown_level, battery_sample, tick,
    input  ready
  );
  modport sink (
    input  valid, button_level, host_shutdown_level, battery_sample, tick,
    output ready
  );
endinterface

interface pbs_status_if;
  logic valid;
  logic ready;
  logic power_enable;
  logic shutdown_request;
  logic forward_press;
  logic low_battery_alert;

  modport source (
    output valid, power_enable, shutdown_request, forward_press, low_battery_alert,
    input  ready
  );
  modport sink (
    input  valid, power_enable, shutdown_request, forward_press, low_battery_alert,
    output ready
  );
endinterface

[rtl/pbs_div.sv]
// Restoring divider, one quotient bit per cycle, for the battery average.
module pbs_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] work;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work <= {work[NUM_W-2:0], fits};
    end
  end

  assign quotient = work;

endmodule

[rtl/power_button_sequencer_core.sv]
// Power button sequencer: debounce, hold timers, battery average check, shutdown wait.
// Pass: an accepted word runs through S_TIME, S_DEB, S_STAB, S_DECIDE and S_DONE;
//   S_ACC comes in when the sample is averaged, and S_DIV, waiting on the 32-step
//   divide, for a power-on decision. One word at a time: pins.ready is low from
//   acceptance until the result is loaded into the output register.
// Reset: synchronous active-high rst clears control state and restores register defaults.
module power_button_sequencer_core #(
  parameter int SAMPLE_COUNT_BITS = pbs_pkg::SAMPLE_COUNT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  pbs_pins_if.sink                        pins,
  pbs_status_if.source                    status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pbs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pbs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pbs_pkg::*;

  localparam int CNT_W = SAMPLE_COUNT_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TIME   = 3'd1;
  localparam logic [2:0] S_DEB    = 3'd2;
  localparam logic [2:0] S_STAB   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_ACC    = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;

  // Configuration registers
  logic [HOLD_W-1:0]     power_on_hold_ms;
  logic [HOLD_W-1:0]     power_off_hold_ms;
  logic [HOLD_W-1:0]     shutdown_wait_ms;
  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [THRESH_W-1:0]   battery_threshold_mv;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_write;

  // Latched input word
  logic                button_level;
  logic                host_shutdown_level;
  logic [SAMPLE_W-1:0] battery_sample;
  logic                tick;
  logic                pressed;
  logic                host_down;

  // Sequencer state
  logic [TIME_W-1:0] time_now;
  logic [TIME_W-1:0] debounce_deadline;
  logic              shutdown_raw_prev;
  logic              shutdown_stable;
  logic              power_is_on;
  logic              shutdown_pending;
  logic              shutdown_out_level;
  logic              hold_timer_running;
  logic [TIME_W-1:0] hold_deadline;
  logic              wait_timer_running;
  logic [TIME_W-1:0] wait_deadline;
  logic              button_prev;
  logic [SUM_W-1:0]  battery_sum;
  logic [CNT_W-1:0]  battery_count;
  logic              need_cmp;
  logic              forward;
  logic              alert;

  // Output register
  logic out_valid;
  logic out_power_enable;
  logic out_shutdown_request;
  logic out_forward_press;
  logic out_low_battery_alert;

  // Accumulate and divide
  logic [SUM_W:0]     sum_ext;
  logic               acc_ok;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   count_next;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quotient;
  logic               shutting;
  logic               pins_take;
  logic               out_free;

  assign pressed   = ~button_level;
  assign host_down = ~host_shutdown_level;
  assign shutting  = power_is_on & (shutdown_stable | shutdown_pending);

  assign pins.ready = (state == S_IDLE);
  assign pins_take  = pins.valid & pins.ready;
  assign out_free   = ~out_valid | status.ready;

  // Configuration port: always ready, write on the access cycle
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_hold_ms     <= ON_HOLD_RST;
      power_off_hold_ms    <= OFF_HOLD_RST;
      shutdown_wait_ms     <= SHDN_WAIT_RST;
      debounce_ms          <= DEBOUNCE_RST;
      battery_threshold_mv <= BATT_THR_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ON_HOLD:   power_on_hold_ms     <= pwdata[HOLD_W-1:0];
        REG_OFF_HOLD:  power_off_hold_ms    <= pwdata[HOLD_W-1:0];
        REG_SHDN_WAIT: shutdown_wait_ms     <= pwdata[HOLD_W-1:0];
        REG_DEBOUNCE:  debounce_ms          <= pwdata[DEBOUNCE_W-1:0];
        REG_BATT_THR:  battery_threshold_mv <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_idx)
      REG_ON_HOLD:   prdata = APB_DATA_W'(power_on_hold_ms);
      REG_OFF_HOLD:  prdata = APB_DATA_W'(power_off_hold_ms);
      REG_SHDN_WAIT: prdata = APB_DATA_W'(shutdown_wait_ms);
      REG_DEBOUNCE:  prdata = APB_DATA_W'(debounce_ms);
      REG_BATT_THR:  prdata = APB_DATA_W'(battery_threshold_mv);
      default:       prdata = '0;
    endcase
  end

  // Accumulate four times the sample unless the count is full or the sum would wrap
  assign sum_ext    = {1'b0, battery_sum} + (SUM_W + 1)'({battery_sample, 2'b00});
  assign acc_ok     = (battery_count != {CNT_W{1'b1}}) & ~sum_ext[SUM_W];
  assign sum_next   = acc_ok ? sum_ext[SUM_W-1:0] : battery_sum;
  assign count_next = acc_ok ? battery_count + 1'b1 : battery_count;
  assign div_start  = (state == S_ACC) & need_cmp;

  pbs_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (pins_take) begin
      button_level        <= pins.button_level;
      host_shutdown_level <= pins.host_shutdown_level;
      battery_sample      <= pins.battery_sample;
      tick                <= pins.tick;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      time_now           <= '0;
      debounce_deadline  <= '0;
      shutdown_raw_prev  <= 1'b0;
      shutdown_stable    <= 1'b0;
      power_is_on        <= 1'b0;
      shutdown_pending   <= 1'b0;
      shutdown_out_level <= 1'b0;
      hold_timer_running <= 1'b0;
      hold_deadline      <= '0;
      wait_timer_running <= 1'b0;
      wait_deadline      <= '0;
      button_prev        <= 1'b0;
      battery_sum        <= '0;
      battery_count      <= '0;
      need_cmp           <= 1'b0;
      forward            <= 1'b0;
      alert              <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pins_take) begin
            forward  <= 1'b0;
            alert    <= 1'b0;
            need_cmp <= 1'b0;
            state    <= S_TIME;
          end
        end
        // Advance the millisecond clock
        S_TIME: begin
          time_now <= time_now + TIME_W'(tick);
          state    <= S_DEB;
        end
        // Restart the debounce window on a pin change
        S_DEB: begin
          if (host_down != shutdown_raw_prev) begin
            debounce_deadline <= time_now + TIME_W'(debounce_ms);
          end
          state <= S_STAB;
        end
        S_STAB: begin
          if (time_now > debounce_deadline) begin
            shutdown_stable <= host_down;
          end
          shutdown_raw_prev <= host_down;
          state             <= S_DECIDE;
        end
        // Shutdown wait, hold timer, or release handling
        S_DECIDE: begin
          button_prev <= pressed;
          // Fold the sample into the average while a power-on hold is running
          state       <= (!shutting && pressed && hold_timer_running && !power_is_on) ?
                         S_ACC : S_DONE;
          if (shutting) begin
            if (!wait_timer_running) begin
              wait_timer_running <= 1'b1;
              wait_deadline      <= time_now + TIME_W'(shutdown_wait_ms);
              shutdown_out_level <= 1'b1;
              shutdown_pending   <= 1'b1;
            end else if (time_now > wait_deadline) begin
              wait_timer_running <= 1'b0;
              power_is_on        <= 1'b0;
              shutdown_out_level <= 1'b0;
              shutdown_pending   <= 1'b0;
            end
          end else if (pressed) begin
            if (!hold_timer_running) begin
              hold_timer_running <= 1'b1;
              battery_count      <= '0;
              battery_sum        <= '0;
              hold_deadline      <= time_now +
                TIME_W'(power_is_on ? power_off_hold_ms : power_on_hold_ms);
            end else if (time_now > hold_deadline) begin
              hold_timer_running <= 1'b0;
              if (power_is_on) begin
                shutdown_out_level <= 1'b1;
                shutdown_pending   <= 1'b1;
              end else begin
                need_cmp <= 1'b1;
              end
            end
          end else if (button_prev && hold_timer_running) begin
            forward <= 1'b1;
          end else begin
            hold_timer_running <= 1'b0;
          end
        end
        // Fold the sample into the running average; divide if a decision is due
        S_ACC: begin
          battery_sum   <= sum_next;
          battery_count <= count_next;
          state         <= need_cmp ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            if ((battery_count != '0) &&
                (div_quotient > SUM_W'(battery_threshold_mv))) begin
              power_is_on <= 1'b1;
            end else begin
              alert <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when the pass finishes, drop when the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_power_enable      <= power_is_on;
      out_shutdown_request  <= shutdown_out_level;
      out_forward_press     <= forward;
      out_low_battery_alert <= alert;
    end
  end

  assign status.valid             = out_valid;
  assign status.power_enable      = out_power_enable;
  assign status.shutdown_request  = out_shutdown_request;
  assign status.forward_press     = out_forward_press;
  assign status.low_battery_alert = out_low_battery_alert;

endmodule

[rtl/pbs_checker.sv]
// Port-level checks for the power button sequencer, bound to the top level.
module pbs_checker (
  input logic clk,
  input logic rst,
  input logic pins_valid,
  input logic pins_ready,
  input logic status_valid,
  input logic status_ready,
  input logic power_enable,
  input logic shutdown_request,
  input logic forward_press,
  input logic low_battery_alert
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=>
      $stable({power_enable, shutdown_request, forward_press, low_battery_alert}))
    else $error("result word changed while stalled");

  // The sequencer is busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    pins_valid && pins_ready |=> !pins_ready)
    else $error("new word taken before the pass finished");

  // A short press and a refused power-on never share one pass
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> !(forward_press && low_battery_alert))
    else $error("forward press and low battery alert in one word");

  // A refused power-on leaves the regulator off
  a_alert_off: assert property (@(posedge clk) disable iff (rst)
    status_valid && low_battery_alert |-> !power_enable)
    else $error("low battery alert with power enabled");

endmodule

bind power_button_sequencer_core pbs_checker u_pbs_checker (
  .clk               (clk),
  .rst               (rst),
  .pins_valid        (pins.valid),
  .pins_ready        (pins.ready),
  .status_valid      (status.valid),
  .status_ready      (status.ready),
  .power_enable      (status.power_enable),
  .shutdown_request  (status.shutdown_request),
  .forward_press     (status.forward_press),
  .low_battery_alert (status.low_battery_alert)
);

[tb/tb_power_button_sequencer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the power button sequencer core.
module tb_power_button_sequencer_core;
  import pbs_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_WORDS    = 240;
  localparam int CNT_BITS       = SAMPLE_COUNT_BITS_DEFAULT;
  localparam logic [31:0] CNT_FULL = (32'd1 << CNT_BITS) - 32'd1;

  typedef struct {
    logic                button_level;
    logic                host_shutdown_level;
    logic [SAMPLE_W-1:0] battery_sample;
    logic                tick;
  } pass_word_t;

  typedef struct {
    logic power_enable;
    logic shutdown_request;
    logic forward_press;
    logic low_battery_alert;
  } status_word_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pbs_pins_if   pins_ch ();
  pbs_status_if status_ch ();

  power_button_sequencer_core dut (
    .clk     (clk),
    .rst     (rst),
    .pins    (pins_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Sequencer settings as last written
  logic [HOLD_W-1:0]     on_hold_ms;
  logic [HOLD_W-1:0]     off_hold_ms;
  logic [HOLD_W-1:0]     wait_ms;
  logic [DEBOUNCE_W-1:0] settle_ms;
  logic [THRESH_W-1:0]   thresh_mv;

  // Sequencer state mirror
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] host_settle_at;
  logic [TIME_W-1:0] hold_end_at;
  logic [TIME_W-1:0] cut_at;
  logic [SUM_W-1:0]  adc_sum;
  logic [31:0]       adc_cnt;
  logic host_prev, host_settled, rail_on, cut_pending, req_level;
  logic hold_armed, cut_armed, btn_was_down;

  pass_word_t   pass_queue[$];
  status_word_t status_due[$];
  pass_word_t   cur_pass;

  int planned        = 0;
  int passes_taken   = 0;
  int results_seen   = 0;
  int fault_count    = 0;
  int reported       = 0;
  int settings_used  = 0;
  int power_ups      = 0;
  int fwd_seen       = 0;
  int alerts_seen    = 0;
  int holdoff_reqs   = 0;
  int holdoff_seen   = 0;
  int holdoff_left   = 0;
  int rx_mode        = 0;
  int mode_left      = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int cycle_count    = 0;
  logic last_power   = 1'b0;

  function automatic void reset_model();
    on_hold_ms   = ON_HOLD_RST;
    off_hold_ms  = OFF_HOLD_RST;
    wait_ms      = SHDN_WAIT_RST;
    settle_ms    = DEBOUNCE_RST;
    thresh_mv    = BATT_THR_RST;
    now_ms       = '0;
    host_settle_at = '0;
    hold_end_at  = '0;
    cut_at       = '0;
    adc_sum      = '0;
    adc_cnt      = '0;
    host_prev    = 1'b0;
    host_settled = 1'b0;
    rail_on      = 1'b0;
    cut_pending  = 1'b0;
    req_level    = 1'b0;
    hold_armed   = 1'b0;
    cut_armed    = 1'b0;
    btn_was_down = 1'b0;
  endfunction

  // Add four times the sample unless the count is full or the sum would overflow; return the average
  function automatic logic [SUM_W-1:0] running_average(input logic [SAMPLE_W-1:0] adc);
    logic [SUM_W-1:0] add;
    add = {{(SUM_W-SAMPLE_W-2){1'b0}}, adc, 2'b00};
    if (adc_cnt < CNT_FULL && adc_sum <= {SUM_W{1'b1}} - add) begin
      adc_sum = adc_sum + add;
      adc_cnt = adc_cnt + 32'd1;
    end
    if (adc_cnt == 32'd0) return '0;
    return adc_sum / adc_cnt;
  endfunction

  // Advance the mirror by one sampling pass and return the status it leaves
  function automatic status_word_t predict_status(input pass_word_t w);
    status_word_t r;
    logic down, host_down, shutting;
    r = '{default: 1'b0};
    down = !w.button_level;
    host_down = !w.host_shutdown_level;
    if (w.tick) now_ms = now_ms + 32'd1;

    // Debounce the host pin
    if (host_down != host_prev) host_settle_at = now_ms + 32'(settle_ms);
    if (now_ms > host_settle_at) host_settled = host_down;
    host_prev = host_down;
    shutting = rail_on && (host_settled || cut_pending);

    if (shutting) begin
      if (!cut_armed) begin
        cut_armed   = 1'b1;
        cut_at      = now_ms + 32'(wait_ms);
        req_level   = 1'b1;
        cut_pending = 1'b1;
      end else if (now_ms > cut_at) begin
        cut_armed   = 1'b0;
        rail_on     = 1'b0;
        req_level   = 1'b0;
        cut_pending = 1'b0;
      end
    end else if (down) begin
      if (!hold_armed) begin
        hold_armed  = 1'b1;
        adc_cnt     = '0;
        adc_sum     = '0;
        hold_end_at = now_ms + 32'(rail_on ? off_hold_ms : on_hold_ms);
      end else if (now_ms > hold_end_at) begin
        hold_armed = 1'b0;
        if (rail_on) begin
          req_level   = 1'b1;
          cut_pending = 1'b1;
        end else if (running_average(w.battery_sample) > 32'(thresh_mv)) begin
          rail_on = 1'b1;
        end else begin
          r.low_battery_alert = 1'b1;
        end
      end else if (!rail_on) begin
        void'(running_average(w.battery_sample));
      end
    end else if (btn_was_down && hold_armed) begin
      r.forward_press = 1'b1;
    end else begin
      hold_armed = 1'b0;
    end
    btn_was_down = down;

    r.power_enable     = rail_on;
    r.shutdown_request = req_level;
    return r;
  endfunction

  // Queue one sampling pass, clamping the sample into range
  task automatic push_pass(input logic btn, input logic host, input int adc,
                           input logic tk);
    pass_word_t w;
    if (adc < 0) adc = 0;
    if (adc > 1023) adc = 1023;
    w.button_level        = btn;
    w.host_shutdown_level = host;
    w.battery_sample      = SAMPLE_W'(adc);
    w.tick                = tk;
    pass_queue.push_back(w);
    planned++;
  endtask

  // Hold the button past the longer hold time if under 24, else for 4 to 24 ticks
  task automatic long_press();
    int need, ticks, passes, level;
    logic tk;
    need = (on_hold_ms > off_hold_ms) ? int'(on_hold_ms) : int'(off_hold_ms);
    need = (need < 24) ? need + int'($urandom_range(1, 3)) : int'($urandom_range(4, 24));
    if ($urandom_range(0, 3) == 0) level = int'($urandom_range(0, 1023));
    else level = int'(thresh_mv) / 4 + int'($urandom_range(0, 8)) - 4;
    ticks = 0;
    passes = 0;
    while (ticks < need && passes < 48) begin
      tk = ($urandom_range(0, 5) != 0);
      push_pass(1'b0, 1'b1, level + int'($urandom_range(0, 4)) - 2, tk);
      ticks += int'(tk);
      passes++;
    end
    repeat ($urandom_range(1, 3))
      push_pass(1'b1, 1'b1, int'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  task automatic short_press();
    repeat ($urandom_range(1, 3))
      push_pass(1'b0, 1'b1, int'($urandom_range(0, 1023)), ($urandom_range(0, 3) == 0));
    repeat ($urandom_range(1, 2))
      push_pass(1'b1, 1'b1, int'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  // Bounce the host pin, hold it low past a debounce below 28, then bounce back
  task automatic host_shutdown();
    int n;
    repeat ($urandom_range(0, 3))
      push_pass(1'b1, 1'($urandom_range(0, 1)), int'($urandom_range(0, 1023)), 1'b1);
    n = (settle_ms < 28) ? int'(settle_ms) + 2 : int'($urandom_range(2, 30));
    repeat (n)
      push_pass(($urandom_range(0, 7) != 0), 1'b0, int'($urandom_range(0, 1023)),
                ($urandom_range(0, 7) != 0));
    repeat ($urandom_range(1, 4))
      push_pass(1'b1, ($urandom_range(0, 3) != 0), int'($urandom_range(0, 1023)), 1'b1);
  endtask

  // Let time pass with the button released so a shutdown wait can run out
  task automatic quiet_run();
    int n;
    n = (wait_ms < 28) ? int'(wait_ms) + 2 : int'($urandom_range(2, 30));
    repeat (n)
      push_pass(1'b1, 1'b1, int'($urandom_range(0, 1023)), ($urandom_range(0, 5) != 0));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      push_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                int'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_mix(input int quota);
    int stop;
    stop = planned + quota;
    while (planned < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: long_press();
        4, 5:       short_press();
        6:          host_shutdown();
        7:          quiet_run();
        default:    noise_burst();
      endcase
    end
  endtask

  // Wait until every queued word is sent and every status word is back
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pass_queue.size() == 0 && !pins_ch.valid && status_due.size() == 0));
  endtask

  // Write one register with a setup and an access cycle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ON_HOLD:   on_hold_ms  = value[HOLD_W-1:0];
      REG_OFF_HOLD:  off_hold_ms = value[HOLD_W-1:0];
      REG_SHDN_WAIT: wait_ms     = value[HOLD_W-1:0];
      REG_DEBOUNCE:  settle_ms   = value[DEBOUNCE_W-1:0];
      REG_BATT_THR:  thresh_mv   = value[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // Write all five registers, optionally with junk above each register's width
  task automatic load_settings(input int on_v, input int off_v, input int wait_v,
                               input int deb_v, input int thr_v, input bit junk);
    logic [31:0] hi;
    hi = junk ? 32'($urandom) : 32'd0;
    write_reg(REG_ON_HOLD,   (hi << HOLD_W) | 32'(on_v));
    write_reg(REG_OFF_HOLD,  (hi << HOLD_W) | 32'(off_v));
    write_reg(REG_SHDN_WAIT, (hi << HOLD_W) | 32'(wait_v));
    write_reg(REG_DEBOUNCE,  (hi << DEBOUNCE_W) | 32'(deb_v));
    write_reg(REG_BATT_THR,  (hi << THRESH_W) | 32'(thr_v));
    settings_used++;
  endtask

  // Sender: offer queued words in bursts with random gaps, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      pins_ch.valid <= 1'b0;
    end else begin
      if (pins_ch.valid && pins_ch.ready) begin
        status_due.push_back(predict_status(cur_pass));
        passes_taken++;
      end
      if (!pins_ch.valid || pins_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pins_ch.valid <= 1'b0;
        end else if (pass_queue.size() > 0) begin
          cur_pass = pass_queue.pop_front();
          pins_ch.valid               <= 1'b1;
          pins_ch.button_level        <= cur_pass.button_level;
          pins_ch.host_shutdown_level <= cur_pass.host_shutdown_level;
          pins_ch.battery_sample      <= cur_pass.battery_sample;
          pins_ch.tick                <= cur_pass.tick;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          pins_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each status word, stall on a pattern and on hold-off requests
  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          fault_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("status word %0d arrived with nothing expected", results_seen);
          end
        end else begin
          status_word_t want;
          want = status_due.pop_front();
          if (want.power_enable !== status_ch.power_enable ||
              want.shutdown_request !== status_ch.shutdown_request ||
              want.forward_press !== status_ch.forward_press ||
              want.low_battery_alert !== status_ch.low_battery_alert) begin
            fault_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("status word %0d: expected en=%0b req=%0b fwd=%0b low=%0b, got en=%0b req=%0b fwd=%0b low=%0b",
                       results_seen, want.power_enable, want.shutdown_request,
                       want.forward_press, want.low_battery_alert,
                       status_ch.power_enable, status_ch.shutdown_request,
                       status_ch.forward_press, status_ch.low_battery_alert);
            end
          end
        end
        if (status_ch.power_enable === 1'b1 && last_power !== 1'b1) power_ups++;
        last_power = status_ch.power_enable;
        if (status_ch.forward_press === 1'b1) fwd_seen++;
        if (status_ch.low_battery_alert === 1'b1) alerts_seen++;
      end

      if (holdoff_left > 0) begin
        holdoff_left--;
        status_ch.ready <= 1'b0;
      end else if (holdoff_seen != holdoff_reqs) begin
        holdoff_seen++;
        holdoff_left = HOLDOFF_CYCLES;
        status_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       status_ch.ready <= 1'b1;
          1:       status_ch.ready <= 1'($urandom_range(0, 1));
          default: status_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_power_button_sequencer_core: errors");
      $finish;
    end
  end

  initial begin
    int phase;
    pins_ch.valid               = 1'b0;
    pins_ch.button_level        = 1'b1;
    pins_ch.host_shutdown_level = 1'b1;
    pins_ch.battery_sample      = '0;
    pins_ch.tick                = 1'b0;
    status_ch.ready             = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Default settings: sample extremes, short presses, host pin bounce
    push_pass(1'b1, 1'b1, 0, 1'b0);
    push_pass(1'b1, 1'b1, 1023, 1'b1);
    push_pass(1'b0, 1'b1, 1023, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b1, 1'b1, 0, 1'b0);
    push_pass(1'b1, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b0, 682, 1'b1);
    push_pass(1'b1, 1'b1, 341, 1'b1);
    push_pass(1'b1, 1'b0, 1023, 1'b1);
    wait_drained();

    // Short holds: power on, long press while on, shutdown wait, low battery
    load_settings(0, 1, 1, 0, 2000, 1'b0);
    push_pass(1'b0, 1'b1, 1023, 1'b1);
    push_pass(1'b0, 1'b1, 1023, 1'b1);
    push_pass(1'b1, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b0);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 0, 1'b1);
    push_pass(1'b1, 1'b1, 0, 1'b1);
    push_pass(1'b0, 1'b1, 100, 1'b1);
    push_pass(1'b0, 1'b1, 100, 1'b1);
    push_pass(1'b1, 1'b1, 0, 1'b0);
    push_pass(1'b1, 1'b0, 0, 1'b1);
    push_pass(1'b1, 1'b0, 0, 1'b1);
    wait_drained();

    // Random phases: all-zero settings, all-max settings, then mostly small holds
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: load_settings(0, 0, 0, 0, 0, 1'b0);
        1: load_settings(65535, 65535, 65535, 1023, 8191, 1'b0);
        2: load_settings($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 10),
                         $urandom_range(0, 5), 8191, 1'b1);
        default: load_settings($urandom_range(0, 6), $urandom_range(0, 8),
                               $urandom_range(0, 10), $urandom_range(0, 5),
                               $urandom_range(0, 4200), 1'b1);
      endcase
      if (phase == 1) begin
        run_mix(60);
      end else if (phase == 4) begin
        // Pause the sender mid-phase until every status word is back
        run_mix(PHASE_WORDS / 2);
        wait_drained();
        run_mix(PHASE_WORDS / 2);
      end else begin
        run_mix(PHASE_WORDS);
        // Starve the output so the core backs up onto its input
        if (phase == 3 || phase == 6) holdoff_reqs++;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sampling passes over %0d register settings, checked %0d status words.",
             passes_taken, settings_used + 1, results_seen);
    $display("Seen %0d power-ups, %0d forwarded presses, %0d low-battery refusals; %0d faults.",
             power_ups, fwd_seen, alerts_seen, fault_count);
    if (fault_count == 0) begin
      $display("tb_power_button_sequencer_core: clean");
    end else begin
      $display("tb_power_button_sequencer_core: errors");
    end
    $finish;
  end

endmodule
